/* hdl/dorc_pkg.sv */
// ----------------------------------------------------------------------------
// dorc_pkg
// Shared widths, register indexes and defaults of the dimension-order route
// compute block.
// ----------------------------------------------------------------------------
`default_nettype none

package dorc_pkg;

	localparam int ID_W       = 16;
	localparam int NDIMS_W    = 3;
	localparam int SIZE_W     = 5;
	localparam int PORT_W     = 6;
	localparam int RDIM_W     = 2;
	localparam int HOPS_W     = 3;

	localparam int S_TDATA_W  = 32;
	localparam int M_TDATA_W  = 16;
	localparam int M_TUSER_W  = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 5;

	localparam int NUM_SIZE_REGS    = 4;
	localparam int MAX_DIMS_DEF     = 4;
	localparam int MAX_DIM_SIZE_DEF = 16;

	// reciprocal scale: exact floor division of a 16-bit id by sizes up to 64
	localparam int RCP_K = ID_W + 6;
	localparam int RCP_W = RCP_K + 1;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_3 = 3'd4;

	localparam logic [NDIMS_W-1:0] NUM_DIMS_RST = 3'd4;
	localparam logic [SIZE_W-1:0]  DIM_SIZE_RST = 5'd2;

endpackage

`default_nettype wire

/* hdl/dorc_dim_stage.sv */
// ----------------------------------------------------------------------------
// dorc_dim_stage
// Two pipeline stages for one dimension: split off the coordinate of both ids
// by reciprocal multiply, compare them and update the route.
// ----------------------------------------------------------------------------
`default_nettype none

module dorc_dim_stage #(
	parameter int MAX_DIMS     = dorc_pkg::MAX_DIMS_DEF,
	parameter int MAX_DIM_SIZE = dorc_pkg::MAX_DIM_SIZE_DEF,
	parameter int DIM          = 0,
	localparam int SZ_W  = $clog2(MAX_DIM_SIZE + 1),
	localparam int OFS_W = $clog2(MAX_DIMS * MAX_DIM_SIZE + 1),
	localparam int RD_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
	localparam int HP_W  = $clog2(MAX_DIMS + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [SZ_W-1:0]           size,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [dorc_pkg::ID_W-1:0] in_qs,
	input  logic [dorc_pkg::ID_W-1:0] in_qd,
	input  logic [OFS_W-1:0]          in_ofs,
	input  logic [OFS_W-1:0]          in_port,
	input  logic [RD_W-1:0]           in_rdim,
	input  logic [HP_W-1:0]           in_hops,
	input  logic                      in_found,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [dorc_pkg::ID_W-1:0] out_qs,
	output logic [dorc_pkg::ID_W-1:0] out_qd,
	output logic [OFS_W-1:0]          out_ofs,
	output logic [OFS_W-1:0]          out_port,
	output logic [RD_W-1:0]           out_rdim,
	output logic [HP_W-1:0]           out_hops,
	output logic                      out_found
);

	localparam int ID_W  = dorc_pkg::ID_W;
	localparam int RCP_K = dorc_pkg::RCP_K;
	localparam int RCP_W = dorc_pkg::RCP_W;
	localparam int PR_W  = ID_W + RCP_W;
	localparam int QS_W  = ID_W + SZ_W;

	logic [RCP_W-1:0] rcp_tab [MAX_DIM_SIZE+1];

	for (genvar gi = 0; gi <= MAX_DIM_SIZE; gi++) begin : g_rcp
		if (gi == 0) begin : g_zero
			assign rcp_tab[gi] = '0;
		end else begin : g_val
			localparam longint unsigned RV = ((64'd1 << RCP_K) + gi - 1) / gi;
			assign rcp_tab[gi] = RCP_W'(RV);
		end
	end

	logic             va_s1;
	logic [ID_W-1:0]  xs_s1, xd_s1;
	logic [PR_W-1:0]  ps_s1, pd_s1;
	logic [OFS_W-1:0] ofs_s1, port_s1;
	logic [RD_W-1:0]  rdim_s1;
	logic [HP_W-1:0]  hops_s1;
	logic             found_s1;

	logic             vb_s2;
	logic [ID_W-1:0]  qs_s2, qd_s2;
	logic [OFS_W-1:0] ofs_s2, port_s2;
	logic [RD_W-1:0]  rdim_s2;
	logic [HP_W-1:0]  hops_s2;
	logic             found_s2;

	logic             rdy_a, rdy_b;
	logic [RCP_W-1:0] rcp;
	logic [ID_W-1:0]  qs_c, qd_c;
	logic [QS_W-1:0]  ms_c, md_c;
	logic [SZ_W-1:0]  rs_c, rd_c;
	logic             diff_c;
	logic [OFS_W-1:0] port_c;
	logic [RD_W-1:0]  rdim_c;
	logic [HP_W-1:0]  hops_c;
	logic             found_c;

	assign rdy_b    = !vb_s2 || out_ready;
	assign rdy_a    = !va_s1 || rdy_b;
	assign in_ready = rdy_a;
	assign rcp      = rcp_tab[size];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_s1 <= 1'b0;
		end else if (rdy_a) begin
			va_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_a) begin
			xs_s1    <= in_qs;
			xd_s1    <= in_qd;
			ps_s1    <= PR_W'(in_qs) * PR_W'(rcp);
			pd_s1    <= PR_W'(in_qd) * PR_W'(rcp);
			ofs_s1   <= in_ofs;
			port_s1  <= in_port;
			rdim_s1  <= in_rdim;
			hops_s1  <= in_hops;
			found_s1 <= in_found;
		end
	end

	always_comb begin
		qs_c    = ps_s1[RCP_K +: ID_W];
		qd_c    = pd_s1[RCP_K +: ID_W];
		ms_c    = QS_W'(qs_c) * QS_W'(size);
		md_c    = QS_W'(qd_c) * QS_W'(size);
		rs_c    = SZ_W'(xs_s1 - ID_W'(ms_c));
		rd_c    = SZ_W'(xd_s1 - ID_W'(md_c));
		diff_c  = rs_c != rd_c;
		port_c  = port_s1;
		rdim_c  = rdim_s1;
		hops_c  = hops_s1;
		found_c = found_s1;
		if (diff_c) begin
			hops_c = hops_s1 + HP_W'(1);
			if (!found_s1) begin
				found_c = 1'b1;
				port_c  = ofs_s1 + OFS_W'(rd_c);
				rdim_c  = RD_W'(DIM);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vb_s2 <= 1'b0;
		end else if (rdy_b) begin
			vb_s2 <= va_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (va_s1 && rdy_b) begin
			qs_s2    <= qs_c;
			qd_s2    <= qd_c;
			ofs_s2   <= ofs_s1 + OFS_W'(size);
			port_s2  <= port_c;
			rdim_s2  <= rdim_c;
			hops_s2  <= hops_c;
			found_s2 <= found_c;
		end
	end

	assign out_valid = vb_s2;
	assign out_qs    = qs_s2;
	assign out_qd    = qd_s2;
	assign out_ofs   = ofs_s2;
	assign out_port  = port_s2;
	assign out_rdim  = rdim_s2;
	assign out_hops  = hops_s2;
	assign out_found = found_s2;

`ifndef SYNTHESIS
	a_found_hops: assert property (@(posedge clk) disable iff (!arst_n)
		vb_s2 |-> (found_s2 == (hops_s2 != '0)))
		else $error("route found flag disagrees with hop count");
	a_port_below_ofs: assert property (@(posedge clk) disable iff (!arst_n)
		vb_s2 && found_s2 |-> port_s2 < ofs_s2)
		else $error("port beyond offset of processed dimensions");
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		vb_s2 && !out_ready |=> vb_s2 && $stable(port_s2) && $stable(hops_s2))
		else $error("stalled stage lost its item");
`endif

endmodule

`default_nettype wire

/* hdl/dimension_order_route_compute.sv */
// ----------------------------------------------------------------------------
// dimension_order_route_compute
// Dimension-order route computation for a generalized hypercube router:
// per-dimension coordinate split, first differing dimension picks the port.
// ----------------------------------------------------------------------------
// channel  dir  handshake           payload
// s_*      in   tvalid/tready       tdata: src_switch, dst_switch
// m_*      out  tvalid/tready       tdata: out_port, route_dim, hop_distance
//                                   tuser: at_destination, out_of_range
// cfg_*    in   cfg_we              cfg_idx, cfg_wdata
//
// One transfer per cycle in unless m_tready stalls it; there are two stages per
// dimension (reciprocal multiply, then remainder and compare) plus the output
// register. Every stage stalls on its own, so bubbles squeeze out under
// backpressure. Reset clears all valid bits and loads four dimensions of size 2.
// ----------------------------------------------------------------------------
`default_nettype none

module dimension_order_route_compute #(
	parameter int MAX_DIMS     = dorc_pkg::MAX_DIMS_DEF,
	parameter int MAX_DIM_SIZE = dorc_pkg::MAX_DIM_SIZE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [dorc_pkg::S_TDATA_W-1:0]  s_tdata,  // src_switch, dst_switch
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [dorc_pkg::M_TDATA_W-1:0]  m_tdata,  // out_port, route_dim, hop_distance
	output logic [dorc_pkg::M_TUSER_W-1:0]  m_tuser,  // at_destination, out_of_range
	input  logic                            cfg_we,
	input  logic [dorc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [dorc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	localparam int ID_W    = dorc_pkg::ID_W;
	localparam int SZ_W    = $clog2(MAX_DIM_SIZE + 1);
	localparam int OFS_W   = $clog2(MAX_DIMS * MAX_DIM_SIZE + 1);
	localparam int RD_W    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int HP_W    = $clog2(MAX_DIMS + 1);
	localparam int ND_W    = $clog2(MAX_DIMS + 1);
	localparam int NSR     = dorc_pkg::NUM_SIZE_REGS;
	localparam int PORT_W  = dorc_pkg::PORT_W;
	localparam int RDIM_W  = dorc_pkg::RDIM_W;
	localparam int HOPS_W  = dorc_pkg::HOPS_W;
	localparam int PAD_W   = dorc_pkg::M_TDATA_W - PORT_W - RDIM_W - HOPS_W;

	logic [dorc_pkg::NDIMS_W-1:0] num_dims_q;
	logic [dorc_pkg::SIZE_W-1:0]  size_q [NSR];
	logic [dorc_pkg::CFG_IDX_W-1:0] size_sel;

	assign size_sel = cfg_idx - dorc_pkg::REG_DIM_SIZE_0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_dims_q <= dorc_pkg::NUM_DIMS_RST;
			for (int i = 0; i < NSR; i++) begin
				size_q[i] <= dorc_pkg::DIM_SIZE_RST;
			end
		end else if (cfg_we) begin
			case (cfg_idx)
				dorc_pkg::REG_NUM_DIMS: begin
					num_dims_q <= cfg_wdata[dorc_pkg::NDIMS_W-1:0];
				end
				dorc_pkg::REG_DIM_SIZE_0, dorc_pkg::REG_DIM_SIZE_1,
				dorc_pkg::REG_DIM_SIZE_2, dorc_pkg::REG_DIM_SIZE_3: begin
					size_q[size_sel[1:0]] <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	logic [ND_W-1:0] nd_eff;

	always_comb begin
		if (num_dims_q == '0) begin
			nd_eff = ND_W'(1);
		end else if (32'(num_dims_q) > MAX_DIMS) begin
			nd_eff = ND_W'(MAX_DIMS);
		end else begin
			nd_eff = ND_W'(num_dims_q);
		end
	end

	logic [SZ_W-1:0] eff_size [MAX_DIMS];

	for (genvar d = 0; d < MAX_DIMS; d++) begin : g_size
		if (d < NSR) begin : g_reg
			always_comb begin
				if (ND_W'(d) >= nd_eff || size_q[d] == '0) begin
					eff_size[d] = SZ_W'(1);
				end else if (32'(size_q[d]) > MAX_DIM_SIZE) begin
					eff_size[d] = SZ_W'(MAX_DIM_SIZE);
				end else begin
					eff_size[d] = SZ_W'(size_q[d]);
				end
			end
		end else begin : g_one
			assign eff_size[d] = SZ_W'(1);
		end
	end

	logic             ch_valid [MAX_DIMS+1];
	logic             ch_ready [MAX_DIMS+1];
	logic [ID_W-1:0]  ch_qs    [MAX_DIMS+1];
	logic [ID_W-1:0]  ch_qd    [MAX_DIMS+1];
	logic [OFS_W-1:0] ch_ofs   [MAX_DIMS+1];
	logic [OFS_W-1:0] ch_port  [MAX_DIMS+1];
	logic [RD_W-1:0]  ch_rdim  [MAX_DIMS+1];
	logic [HP_W-1:0]  ch_hops  [MAX_DIMS+1];
	logic             ch_found [MAX_DIMS+1];

	assign ch_valid[0] = s_tvalid;
	assign s_tready    = ch_ready[0];
	assign ch_qs[0]    = s_tdata[ID_W-1:0];
	assign ch_qd[0]    = s_tdata[2*ID_W-1:ID_W];
	assign ch_ofs[0]   = '0;
	assign ch_port[0]  = '0;
	assign ch_rdim[0]  = '0;
	assign ch_hops[0]  = '0;
	assign ch_found[0] = 1'b0;

	for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
		dorc_dim_stage #(
			.MAX_DIMS     (MAX_DIMS),
			.MAX_DIM_SIZE (MAX_DIM_SIZE),
			.DIM          (d)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.size      (eff_size[d]),
			.in_valid  (ch_valid[d]),
			.in_ready  (ch_ready[d]),
			.in_qs     (ch_qs[d]),
			.in_qd     (ch_qd[d]),
			.in_ofs    (ch_ofs[d]),
			.in_port   (ch_port[d]),
			.in_rdim   (ch_rdim[d]),
			.in_hops   (ch_hops[d]),
			.in_found  (ch_found[d]),
			.out_valid (ch_valid[d+1]),
			.out_ready (ch_ready[d+1]),
			.out_qs    (ch_qs[d+1]),
			.out_qd    (ch_qd[d+1]),
			.out_ofs   (ch_ofs[d+1]),
			.out_port  (ch_port[d+1]),
			.out_rdim  (ch_rdim[d+1]),
			.out_hops  (ch_hops[d+1]),
			.out_found (ch_found[d+1])
		);
	end

	logic              out_valid_q;
	logic [PORT_W-1:0] out_port_q;
	logic [RDIM_W-1:0] out_rdim_q;
	logic [HOPS_W-1:0] out_hops_q;
	logic              out_atd_q;
	logic              out_oor_q;
	logic              oor_c;
	logic              out_rdy;

	assign out_rdy            = !out_valid_q || m_tready;
	assign ch_ready[MAX_DIMS] = out_rdy;
	assign oor_c = (ch_qs[MAX_DIMS] != '0) || (ch_qd[MAX_DIMS] != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_rdy) begin
			out_valid_q <= ch_valid[MAX_DIMS];
		end
	end

	always_ff @(posedge clk) begin
		if (ch_valid[MAX_DIMS] && out_rdy) begin
			out_oor_q <= oor_c;
			out_atd_q <= !oor_c && !ch_found[MAX_DIMS];
			if (oor_c) begin
				out_port_q <= '0;
				out_rdim_q <= '0;
				out_hops_q <= '0;
			end else begin
				out_port_q <= PORT_W'(ch_port[MAX_DIMS]);
				out_rdim_q <= RDIM_W'(ch_rdim[MAX_DIMS]);
				out_hops_q <= HOPS_W'(ch_hops[MAX_DIMS]);
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_hops_q, out_rdim_q, out_port_q};
	assign m_tuser  = {out_oor_q, out_atd_q};

`ifndef SYNTHESIS
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata == '0 && !m_tuser[0])
		else $error("out of range result carries route fields");
	a_atd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("at destination result carries route fields");
	a_route_hops: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == '0 |-> out_hops_q != '0)
		else $error("routed result with zero hop distance");
`endif

endmodule

`default_nettype wire
